// ----- rtl/hfmt_pkg.sv -----
// Package with shared types and constants for the Hall field magnitude and temperature block.
package hfmt_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMP_REF    = 2'd0;
    localparam logic [1:0] CFG_SENSITIVITY = 2'd1;
    localparam logic [1:0] CFG_PERIOD      = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] REF_RESET    = 16'd46696;
    localparam logic [15:0] SENS_RESET   = 16'd10551;
    localparam logic [15:0] PERIOD_RESET = 16'd1000;

    // Arithmetic constants.
    localparam logic signed [16:0] AXIS_OFFSET  = 17'sh08000;
    localparam logic signed [16:0] TEMP_SCALE   = 17'sd1450;
    localparam logic signed [19:0] TEMP_BASE_Q8 = 20'sd8960;

    // Input action codes.
    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // Result kind codes.
    localparam logic KIND_FIELD = 1'b0;
    localparam logic KIND_TEMP  = 1'b1;

    // Handshake between the sequencer and the square root unit.
    typedef struct packed {
        logic        start;
        logic [31:0] value;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [15:0] root;
    } t_sqrt_rsp;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_TEMP,
        S_ROOT,
        S_SCALE,
        S_FINISH
    } t_state;

endpackage

// ----- rtl/hfmt_isqrt.sv -----
// Iterative 32-bit integer square root, two radicand bits per cycle.
module hfmt_isqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hfmt_pkg::t_sqrt_req i_req,
    output hfmt_pkg::t_sqrt_rsp o_rsp
);
    import hfmt_pkg::*;

    logic [31:0] r_v,    n_v;
    logic [31:0] r_root, n_root;
    logic [3:0]  r_cnt,  n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;

    logic [31:0] bit_val;
    logic [31:0] trial;

    // One digit step: try to subtract root plus the current bit.
    always_comb begin
        bit_val = 32'd1 << {r_cnt, 1'b0};
        trial   = r_root + bit_val;
        n_v     = r_v;
        n_root  = r_root;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_v    = i_req.value;
            n_root = 32'd0;
            n_cnt  = 4'd15;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                n_v    = r_v - trial;
                n_root = (r_root >> 1) + bit_val;
            end else begin
                n_root = r_root >> 1;
            end
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_v    <= n_v;
        r_root <= n_root;
        r_cnt  <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root[15:0];

endmodule

// ----- rtl/hall_field_magnitude_and_temp.sv -----
// Top level: sequencer, shared multiplier and result register for field and temperature reports.
// A measurement transfer yields a field report through three squares and the temperature
// product on the shared 17x17 multiplier, 16 square root steps and one scale step.
// A tick is handled at acceptance; one that ends a period is reported from the finish state.
// No item is taken until a measurement's report is loaded; one tick per cycle when none is due.
// Synchronous active-low reset restores the register defaults and clears count and temperature.
module hall_field_magnitude_and_temp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel.
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_action,
    input  logic [15:0]         i_raw_temp,
    input  logic [15:0]         i_raw_x,
    input  logic [15:0]         i_raw_y,
    input  logic [15:0]         i_raw_z,
    // Output channel.
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_kind,
    output logic [23:0]         o_field_strength,
    output logic signed [19:0]  o_temperature,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import hfmt_pkg::*;

    t_state r_state, n_state;

    logic [15:0] r_temp_ref, r_sens, r_period;
    logic [15:0] r_elapsed, n_elapsed;
    logic signed [19:0] r_latest, n_latest;
    logic [15:0] r_raw_temp, r_raw_x, r_raw_y, r_raw_z;
    logic        r_res_kind, n_res_kind;
    logic [31:0] r_sum, n_sum;
    logic signed [33:0] r_prod;
    logic signed [16:0] mul_a, mul_b;

    logic        r_out_valid, n_out_valid;
    logic        r_out_kind, n_out_kind;
    logic [23:0] r_out_strength, n_out_strength;
    logic signed [19:0] r_out_temp, n_out_temp;

    logic [15:0] tick_count;
    logic        in_xfer, out_free;
    logic signed [33:0] temp_shifted;

    t_sqrt_req sqrt_req;
    t_sqrt_rsp sqrt_rsp;

    hfmt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign in_xfer    = i_valid && o_ready;
    assign out_free   = !r_out_valid || i_ready;
    assign tick_count = r_elapsed + 16'd1;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_state)
            S_SQ_X: begin
                mul_a = $signed({1'b0, r_raw_x}) - AXIS_OFFSET;
                mul_b = mul_a;
            end
            S_SQ_Y: begin
                mul_a = $signed({1'b0, r_raw_y}) - AXIS_OFFSET;
                mul_b = mul_a;
            end
            S_SQ_Z: begin
                mul_a = $signed({1'b0, r_raw_z}) - AXIS_OFFSET;
                mul_b = mul_a;
            end
            S_TEMP: begin
                mul_a = $signed({1'b0, r_raw_temp}) - $signed({1'b0, r_temp_ref});
                mul_b = TEMP_SCALE;
            end
            default: begin
                mul_a = $signed({1'b0, sqrt_rsp.root});
                mul_b = $signed({1'b0, r_sens});
            end
        endcase
    end

    // Temperature product divided by 256 with floor rounding.
    assign temp_shifted = r_prod >>> 8;

    // Sequencer: next state, accumulation and result formation.
    always_comb begin
        n_state        = r_state;
        n_elapsed      = r_elapsed;
        n_latest       = r_latest;
        n_res_kind     = r_res_kind;
        n_sum          = r_sum;
        n_out_valid    = r_out_valid;
        n_out_kind     = r_out_kind;
        n_out_strength = r_out_strength;
        n_out_temp     = r_out_temp;
        sqrt_req.start = 1'b0;
        sqrt_req.value = r_sum + r_prod[31:0];

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_action == ACT_MEASURE) begin
                        n_res_kind = KIND_FIELD;
                        n_state    = S_SQ_X;
                    end else if (tick_count >= r_period) begin
                        n_elapsed  = 16'd0;
                        n_res_kind = KIND_TEMP;
                        n_state    = S_FINISH;
                    end else begin
                        n_elapsed = tick_count;
                    end
                end
            end
            S_SQ_X: n_state = S_SQ_Y;
            S_SQ_Y: begin
                n_sum   = r_prod[31:0];
                n_state = S_SQ_Z;
            end
            S_SQ_Z: begin
                n_sum   = r_sum + r_prod[31:0];
                n_state = S_TEMP;
            end
            S_TEMP: begin
                sqrt_req.start = 1'b1;
                n_state        = S_ROOT;
            end
            S_ROOT: begin
                if (sqrt_rsp.done) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_latest = temp_shifted[19:0] + TEMP_BASE_Q8;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    if (r_res_kind == KIND_FIELD) begin
                        n_out_strength = r_prod[31:8];
                        n_out_temp     = 20'sd0;
                    end else begin
                        n_out_strength = 24'd0;
                        n_out_temp     = r_latest;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, configuration and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_temp_ref  <= REF_RESET;
            r_sens      <= SENS_RESET;
            r_period    <= PERIOD_RESET;
            r_elapsed   <= 16'd0;
            r_latest    <= 20'sd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_latest    <= n_latest;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TEMP_REF:    r_temp_ref <= i_cfg_data;
                    CFG_SENSITIVITY: r_sens     <= i_cfg_data;
                    CFG_PERIOD:      r_period   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        if (in_xfer) begin
            r_raw_temp <= i_raw_temp;
            r_raw_x    <= i_raw_x;
            r_raw_y    <= i_raw_y;
            r_raw_z    <= i_raw_z;
        end
        if (r_state == S_SQ_X || r_state == S_SQ_Y || r_state == S_SQ_Z ||
            r_state == S_TEMP || r_state == S_SCALE) begin
            r_prod <= mul_a * mul_b;
        end
        r_res_kind     <= n_res_kind;
        r_sum          <= n_sum;
        r_out_kind     <= n_out_kind;
        r_out_strength <= n_out_strength;
        r_out_temp     <= n_out_temp;
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_field_strength = r_out_strength;
    assign o_temperature    = r_out_temp;

    // The root unit finishes only while the sequencer waits for it.
    a_root_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_rsp.done |-> r_state == S_ROOT)
        else $error("square root finished outside the wait state");

    // A measurement transfer starts the squaring sequence.
    a_measure_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_action == ACT_MEASURE) |=> r_state == S_SQ_X)
        else $error("measurement did not start the sequence");

    // A finished result is loaded into the output register once the output is free.
    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && out_free) |=> (o_valid && r_state == S_IDLE))
        else $error("finished result not presented");

    // The unused field of a report is zero.
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_kind == KIND_FIELD && o_temperature == 20'sd0) ||
                     (o_kind == KIND_TEMP && o_field_strength == 24'd0)))
        else $error("unused report field not zero");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the Hall field magnitude and temperature reporter.
`timescale 1ns / 1ps

module testbench;
    import hfmt_pkg::*;

    // Register index that decodes to nothing; writes to it must be ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Settling wait; it covers a whole measurement report with margin.
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 75;

    typedef struct {
        logic        action;
        logic [15:0] raw_temp;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [15:0] raw_z;
    } t_hall_item;

    typedef struct {
        logic               kind;
        logic [23:0]        field;
        logic signed [19:0] temp;
    } t_report;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op     op;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        t_hall_item  item;
        int          reps;
        bit          typed;
        t_report     want;
    } t_plan_row;

    // Block ports.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_action = ACT_MEASURE;
    logic [15:0]        i_raw_temp = '0;
    logic [15:0]        i_raw_x = '0;
    logic [15:0]        i_raw_y = '0;
    logic [15:0]        i_raw_z = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_kind;
    logic [23:0]        o_field_strength;
    logic signed [19:0] o_temperature;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;

    // Predictor copy of the configuration and state.
    logic [15:0]        ref_word;
    logic [15:0]        sens_word;
    logic [15:0]        period_ms;
    logic signed [19:0] held_temp;
    logic [15:0]        ms_count;

    t_report   pending_reports [$];
    t_plan_row plan [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        src_gap_max = 9;
    int        snk_gap_max = 9;

    hall_field_magnitude_and_temp DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_raw_temp       (i_raw_temp),
        .i_raw_x          (i_raw_x),
        .i_raw_y          (i_raw_y),
        .i_raw_z          (i_raw_z),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_field_strength (o_field_strength),
        .o_temperature    (o_temperature),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Square of one offset-binary axis word.
    function automatic logic [31:0] axis_square(input logic [15:0] w);
        int d;
        d = int'(w) - int'(AXIS_OFFSET);
        if (d < 0) d = -d;
        return d * d;
    endfunction

    // Floor square root, built up one result bit at a time from the top.
    function automatic logic [15:0] floor_root(input logic [31:0] v);
        logic [15:0] root;
        logic [15:0] trial;
        root = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            if ({16'd0, trial} * {16'd0, trial} <= v) root = trial;
        end
        return root;
    endfunction

    // Raw temperature word to signed Q12.8 degrees, flooring the scaled difference.
    function automatic logic signed [19:0] convert_raw_temp(input logic [15:0] raw);
        longint scaled;
        scaled = (longint'(raw) - longint'(ref_word)) * longint'(TEMP_SCALE);
        return 20'(scaled >>> 8) + TEMP_BASE_Q8;
    endfunction

    // Updates the predicted state for one accepted item; returns 1 if it yields a report.
    function automatic bit predict_report(input t_hall_item it, output t_report rep);
        logic [31:0] sum_sq;
        logic [31:0] product;
        rep.kind  = KIND_FIELD;
        rep.field = '0;
        rep.temp  = '0;
        if (it.action == ACT_MEASURE) begin
            sum_sq = axis_square(it.raw_x) + axis_square(it.raw_y) + axis_square(it.raw_z);
            product = {16'd0, floor_root(sum_sq)} * {16'd0, sens_word};
            rep.field = product[31:8];
            held_temp = convert_raw_temp(it.raw_temp);
            return 1'b1;
        end
        // A tick counts one millisecond; reaching the period reports and clears it.
        ms_count = ms_count + 16'd1;
        if (ms_count >= period_ms) begin
            ms_count = '0;
            rep.kind = KIND_TEMP;
            rep.temp = held_temp;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Compares the report taken in this transfer with the oldest expectation.
    task automatic check_report();
        t_report exp_rep;
        if (pending_reports.size() == 0) begin
            flag_mismatch($sformatf("unexpected report kind=%0d field=%0d temp=%0d",
                                    o_kind, o_field_strength, o_temperature));
            return;
        end
        exp_rep = pending_reports.pop_front();
        if (o_kind !== exp_rep.kind)
            flag_mismatch($sformatf("kind %0d, expected %0d", o_kind, exp_rep.kind));
        if (o_field_strength !== exp_rep.field)
            flag_mismatch($sformatf("field_strength %0d, expected %0d",
                                    o_field_strength, exp_rep.field));
        if (o_temperature !== exp_rep.temp)
            flag_mismatch($sformatf("temperature %0d, expected %0d",
                                    o_temperature, exp_rep.temp));
    endtask

    // Sends one item after a random gap and records what it should produce.
    task automatic send_hall_item(input t_hall_item it, input bit typed, input t_report want);
        int      gap;
        bit      made;
        t_report rep;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= it.action;
        i_raw_temp <= it.raw_temp;
        i_raw_x    <= it.raw_x;
        i_raw_y    <= it.raw_y;
        i_raw_z    <= it.raw_z;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        made = predict_report(it, rep);
        if (typed) pending_reports.push_back(want);
        else if (made) pending_reports.push_back(rep);
    endtask

    // Holds the input side until every expected report has arrived.
    task automatic drain_reports();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    // Register writes happen only with the block drained and settled.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TEMP_REF:    ref_word = val;
            CFG_SENSITIVITY: sens_word = val;
            CFG_PERIOD:      period_ms = val;
            default: ;
        endcase
    endtask

    task automatic plan_item(input logic act, input logic [15:0] t, x, y, z, input int reps);
        t_plan_row row;
        row.op            = ROW_ITEM;
        row.reg_idx       = '0;
        row.reg_val       = '0;
        row.item.action   = act;
        row.item.raw_temp = t;
        row.item.raw_x    = x;
        row.item.raw_y    = y;
        row.item.raw_z    = z;
        row.reps          = reps;
        row.typed         = 1'b0;
        row.want.kind     = KIND_FIELD;
        row.want.field    = '0;
        row.want.temp     = '0;
        plan.push_back(row);
    endtask

    // An item whose report is written out by hand.
    task automatic plan_typed(input logic act, input logic [15:0] t, x, y, z,
                              input logic kind, input logic [23:0] field,
                              input logic signed [19:0] temp);
        plan_item(act, t, x, y, z, 1);
        plan[plan.size() - 1].typed      = 1'b1;
        plan[plan.size() - 1].want.kind  = kind;
        plan[plan.size() - 1].want.field = field;
        plan[plan.size() - 1].want.temp  = temp;
    endtask

    task automatic plan_cfg(input logic [1:0] idx, input logic [15:0] val);
        plan_item(ACT_TICK, '0, '0, '0, '0, 0);
        plan[plan.size() - 1].op      = ROW_CFG;
        plan[plan.size() - 1].reg_idx = idx;
        plan[plan.size() - 1].reg_val = val;
    endtask

    // Uniform words half the time, otherwise near zero field or one of 0000, FFFF, 7FFF and 8000.
    function automatic logic [15:0] random_axis();
        case ($urandom_range(3, 0))
            0: return 16'h8000 + 16'($urandom_range(512, 0)) - 16'd256;
            1: begin
                case ($urandom_range(3, 0))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h7FFF;
                    default: return 16'h8000;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_word(input logic [15:0] usual);
        case ($urandom_range(4, 0))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return usual;
            default: return 16'($urandom);
        endcase
    endfunction

    // Output side: random stalls before each transfer, none in some phases.
    initial begin : report_sink
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = $urandom_range(snk_gap_max, 0);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            check_report();
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("hall_field_magnitude_and_temp verification failed");
        $finish;
    end

    initial begin : stimulus
        t_hall_item  it;
        t_report     none;
        logic [15:0] period_pick;

        none.kind  = KIND_FIELD;
        none.field = '0;
        none.temp  = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        ref_word  = REF_RESET;
        sens_word = SENS_RESET;
        period_ms = PERIOD_RESET;
        held_temp = '0;
        ms_count  = '0;

        // Default period, no measurement yet: the report carries zero degrees.
        plan_item(ACT_TICK, '0, '0, '0, '0, 999);
        plan_typed(ACT_TICK, '0, '0, '0, '0, KIND_TEMP, '0, '0);
        // Default reference and sensitivity: zero vector, then one full-scale axis.
        plan_typed(ACT_MEASURE, REF_RESET, 16'h8000, 16'h8000, 16'h8000,
                   KIND_FIELD, '0, '0);
        plan_typed(ACT_MEASURE, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                   KIND_FIELD, 24'd1350528, '0);
        plan_item(ACT_MEASURE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1);
        plan_item(ACT_MEASURE, 16'h5555, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        plan_item(ACT_MEASURE, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h1234, 1);
        plan_item(ACT_MEASURE, 16'h8000, 16'h7FFF, 16'h8001, 16'h0001, 1);
        plan_cfg(CFG_PERIOD, 16'd1);
        plan_item(ACT_TICK, '0, '0, '0, '0, 1);
        // Largest strength and warmest temperature.
        plan_cfg(CFG_SENSITIVITY, 16'hFFFF);
        plan_cfg(CFG_TEMP_REF, 16'h0000);
        plan_item(ACT_MEASURE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1);
        plan_item(ACT_TICK, '0, '0, '0, '0, 1);
        // Zero sensitivity and coldest temperature.
        plan_cfg(CFG_TEMP_REF, 16'hFFFF);
        plan_cfg(CFG_SENSITIVITY, 16'h0000);
        plan_typed(ACT_MEASURE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   KIND_FIELD, '0, '0);
        plan_item(ACT_TICK, '0, '0, '0, '0, 1);
        // A zero period reports on every tick.
        plan_cfg(CFG_PERIOD, 16'd0);
        plan_item(ACT_TICK, '0, '0, '0, '0, 3);
        // Lowering the period below the running count reports on the next tick.
        plan_cfg(CFG_PERIOD, 16'd10);
        plan_item(ACT_TICK, '0, '0, '0, '0, 7);
        plan_cfg(CFG_PERIOD, 16'd3);
        plan_item(ACT_TICK, '0, '0, '0, '0, 1);
        // A write to the undecoded index leaves the period alone.
        plan_cfg(CFG_UNUSED, 16'd0);
        plan_item(ACT_TICK, '0, '0, '0, '0, 3);
        // Longest period: a run of ticks stays below it and reports nothing.
        plan_cfg(CFG_PERIOD, 16'hFFFF);
        plan_item(ACT_TICK, '0, '0, '0, '0, 40);

        foreach (plan[r]) begin
            if (plan[r].op == ROW_CFG) begin
                write_reg(plan[r].reg_idx, plan[r].reg_val);
            end else begin
                for (int k = 0; k < plan[r].reps; k++)
                    send_hall_item(plan[r].item, plan[r].typed && k == plan[r].reps - 1,
                                   plan[r].want);
            end
        end

        // Random phases, each under its own register setting and idling pattern.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            src_gap_max = (ph % 3 == 1) ? 0 : 9;
            snk_gap_max = (ph % 4 == 2) ? 0 : 9;
            case ($urandom_range(9, 0))
                0: period_pick = 16'd0;
                1: period_pick = 16'hFFFF;
                2: period_pick = 16'($urandom);
                default: period_pick = 16'($urandom_range(12, 1));
            endcase
            write_reg(CFG_TEMP_REF, pick_word(REF_RESET));
            write_reg(CFG_SENSITIVITY, pick_word(SENS_RESET));
            write_reg(CFG_PERIOD, period_pick);
            if (ph % 4 == 3) write_reg(CFG_UNUSED, 16'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Midway through, let the output side catch up completely.
                if (n == PHASE_ITEMS / 2) drain_reports();
                it.action = 1'($urandom_range(1, 0));
                if ($urandom_range(3, 0) == 0)
                    it.raw_temp = ref_word + 16'($urandom_range(200, 0)) - 16'd100;
                else
                    it.raw_temp = 16'($urandom);
                it.raw_x = random_axis();
                it.raw_y = random_axis();
                it.raw_z = random_axis();
                send_hall_item(it, 1'b0, none);
            end
        end

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("hall_field_magnitude_and_temp verification clean");
        else
            $display("hall_field_magnitude_and_temp verification failed");
        $finish;
    end

endmodule
